FILE: hdl/lmts_pkg.sv
// Shared types and constants for the longest-match text substituter.
// Used by lmts_dict, lmts_ctrl and the top level; no dependencies.
package lmts_pkg;

    localparam int CP_W       = 21;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 3;
    localparam int LEN_W      = 4;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;
    // entry and position fields of an internal read request, wide enough
    // for the largest table and key size
    localparam int RD_ENTRY_W = 16;
    localparam int RD_POS_W   = 4;

    typedef enum logic [1:0] {
        ACT_KEY     = 2'd0,
        ACT_VALUE   = 2'd1,
        ACT_LENGTHS = 2'd2,
        ACT_TEXT    = 2'd3
    } action_t;

    typedef struct packed {
        logic [LEN_W-1:0] value_length;
        logic [LEN_W-1:0] key_length;
        logic [CP_W-1:0]  code_point;
        logic [POS_W-1:0] char_position;
        logic [IDX_W-1:0] entry_index;
        action_t          action;
    } item_t;

    typedef struct packed {
        logic                  en;
        logic [RD_ENTRY_W-1:0] entry;
        logic [RD_POS_W-1:0]   pos;
    } rd_req_t;

endpackage

FILE: hdl/lmts_dict.sv
// Dictionary storage: key and value characters and entry lengths.
// Synchronous memories with registered reads. Depends on lmts_pkg.
module lmts_dict #(
    parameter int MAX_KEY_CHARS   = 8,
    parameter int MAX_VALUE_CHARS = 8,
    parameter int TABLE_ENTRIES   = 4096,
    parameter int KLW             = $clog2(MAX_KEY_CHARS + 1),
    parameter int VLW             = $clog2(MAX_VALUE_CHARS + 1)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  lmts_pkg::item_t           wr_item,
    input  lmts_pkg::rd_req_t         key_rd,
    input  lmts_pkg::rd_req_t         val_rd,
    output logic [lmts_pkg::CP_W-1:0] key_char_q,
    output logic [KLW-1:0]            key_len_q,
    output logic [lmts_pkg::CP_W-1:0] val_char_q,
    output logic [VLW-1:0]            val_len_q
);
    localparam int KD  = TABLE_ENTRIES * MAX_KEY_CHARS;
    localparam int VD  = TABLE_ENTRIES * MAX_VALUE_CHARS;
    localparam int KAW = $clog2(KD);
    localparam int VAW = $clog2(VD);
    localparam int EW  = $clog2(TABLE_ENTRIES);

    logic [lmts_pkg::CP_W-1:0] key_mem [KD];
    logic [lmts_pkg::CP_W-1:0] val_mem [VD];
    logic [KLW-1:0]            klen_mem [TABLE_ENTRIES];
    logic [VLW-1:0]            vlen_mem [TABLE_ENTRIES];

    logic          idx_ok;
    logic [KAW-1:0] key_wa, key_ra;
    logic [VAW-1:0] val_wa, val_ra;
    logic [EW-1:0]  wr_entry;
    logic [KLW-1:0] klen_sat;
    logic [VLW-1:0] vlen_sat;

    assign idx_ok   = 32'(wr_item.entry_index) < TABLE_ENTRIES;
    assign wr_entry = EW'(wr_item.entry_index);
    assign key_wa = KAW'(32'(wr_item.entry_index) * MAX_KEY_CHARS + 32'(wr_item.char_position));
    assign val_wa = VAW'(32'(wr_item.entry_index) * MAX_VALUE_CHARS
                         + 32'(wr_item.char_position));
    assign key_ra = KAW'(32'(key_rd.entry) * MAX_KEY_CHARS + 32'(key_rd.pos));
    assign val_ra = VAW'(32'(val_rd.entry) * MAX_VALUE_CHARS + 32'(val_rd.pos));
    assign klen_sat = (32'(wr_item.key_length) > MAX_KEY_CHARS) ? KLW'(MAX_KEY_CHARS)
                                                                : KLW'(wr_item.key_length);
    assign vlen_sat = (32'(wr_item.value_length) > MAX_VALUE_CHARS) ? VLW'(MAX_VALUE_CHARS)
                                                                    : VLW'(wr_item.value_length);

    always_ff @(posedge aclk) begin
        if (wr_en && idx_ok) begin
            unique case (wr_item.action)
                lmts_pkg::ACT_KEY: begin
                    if (32'(wr_item.char_position) < MAX_KEY_CHARS)
                        key_mem[key_wa] <= wr_item.code_point;
                end
                lmts_pkg::ACT_VALUE: begin
                    if (32'(wr_item.char_position) < MAX_VALUE_CHARS)
                        val_mem[val_wa] <= wr_item.code_point;
                end
                lmts_pkg::ACT_LENGTHS: begin
                    klen_mem[wr_entry] <= klen_sat;
                    vlen_mem[wr_entry] <= vlen_sat;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (key_rd.en) begin
            key_char_q <= key_mem[key_ra];
            key_len_q  <= klen_mem[key_rd.entry[EW-1:0]];
        end
        if (val_rd.en) begin
            val_char_q <= val_mem[val_ra];
            val_len_q  <= vlen_mem[val_rd.entry[EW-1:0]];
        end
    end

endmodule

FILE: hdl/lmts_ctrl.sv
// Match sequencer: lookahead window, binary search over the key memory,
// value emission and the output register. Depends on lmts_pkg.
module lmts_ctrl #(
    parameter int MAX_KEY_CHARS   = 8,
    parameter int MAX_VALUE_CHARS = 8,
    parameter int CW              = 13,
    parameter int KLW             = $clog2(MAX_KEY_CHARS + 1),
    parameter int VLW             = $clog2(MAX_VALUE_CHARS + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lmts_pkg::item_t           in_item,
    input  logic                      in_end,
    input  logic [CW-1:0]             hi_init,
    output logic                      wr_en,
    output lmts_pkg::rd_req_t         key_rd,
    output lmts_pkg::rd_req_t         val_rd,
    input  logic [lmts_pkg::CP_W-1:0] key_char_q,
    input  logic [KLW-1:0]            key_len_q,
    input  logic [lmts_pkg::CP_W-1:0] val_char_q,
    input  logic [VLW-1:0]            val_len_q,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lmts_pkg::CP_W-1:0] out_cp,
    output logic                      out_last,
    output logic                      out_eot
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_STEP, ST_SRCH, ST_CMP, ST_VISS, ST_VGET, ST_PASS, ST_SHIFT, ST_FIN
    } state_t;

    state_t                    state_reg;
    logic [lmts_pkg::CP_W-1:0] win_reg [MAX_KEY_CHARS];
    logic [KLW-1:0]            fill_reg, len_reg, used_reg, i_reg;
    logic [VLW-1:0]            j_reg;
    logic [CW-1:0]             lo_reg, hi_reg, mid_reg;
    logic                      end_reg;
    logic [lmts_pkg::CNT_W-1:0] n_reg;
    logic                      pend_valid_reg;
    logic [lmts_pkg::CP_W-1:0] pend_cp_reg;
    logic                      out_valid_reg, out_last_reg, out_eot_reg;
    logic [lmts_pkg::CP_W-1:0] out_cp_reg;

    logic [CW-1:0]             mid_next;
    logic [lmts_pkg::CP_W-1:0] win_i;
    logic                      c_eq, c_lt, c_gt;
    logic                      emit_req, emit_go, emit_keep, fin_go, out_free, push;
    logic [lmts_pkg::CP_W-1:0] emit_cp;
    logic                      accept;
    logic [KLW-1:0]            fill_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign wr_en     = accept && (in_item.action != lmts_pkg::ACT_TEXT);
    assign out_valid = out_valid_reg;
    assign out_cp    = out_cp_reg;
    assign out_last  = out_last_reg;
    assign out_eot   = out_eot_reg;

    assign mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        win_i = '0;
        for (int k = 0; k < MAX_KEY_CHARS; k++)
            if (i_reg == KLW'(k)) win_i = win_reg[k];
    end

    // three-way compare of window[0..len) against the key, one char a cycle
    always_comb begin
        c_eq = 1'b0;
        c_lt = 1'b0;
        c_gt = 1'b0;
        priority if (i_reg == len_reg && i_reg == key_len_q) c_eq = 1'b1;
        else if (i_reg == len_reg) c_lt = 1'b1;
        else if (i_reg == key_len_q) c_gt = 1'b1;
        else if (win_i < key_char_q) c_lt = 1'b1;
        else if (win_i > key_char_q) c_gt = 1'b1;
    end

    always_comb begin
        key_rd = '0;
        val_rd = '0;
        if (state_reg == ST_SRCH && lo_reg < hi_reg) begin
            key_rd.en    = 1'b1;
            key_rd.entry = lmts_pkg::RD_ENTRY_W'(mid_next);
        end else if (state_reg == ST_CMP && !(c_eq || c_lt || c_gt)
                     && 32'(i_reg) + 1 < MAX_KEY_CHARS) begin
            key_rd.en    = 1'b1;
            key_rd.entry = lmts_pkg::RD_ENTRY_W'(mid_reg);
            key_rd.pos   = lmts_pkg::RD_POS_W'(i_reg + KLW'(1));
        end
        if (state_reg == ST_VISS) begin
            val_rd.en    = 1'b1;
            val_rd.entry = lmts_pkg::RD_ENTRY_W'(mid_reg);
            val_rd.pos   = lmts_pkg::RD_POS_W'(j_reg);
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_req  = (state_reg == ST_PASS) || (state_reg == ST_VGET && j_reg < val_len_q);
    assign emit_cp   = (state_reg == ST_PASS) ? win_reg[0] : val_char_q;
    assign emit_keep = 32'(n_reg) < lmts_pkg::RESULT_CAP;
    // a result held back until the next one shows whether it is the last
    assign emit_go   = emit_req && (!emit_keep || !pend_valid_reg || out_free);
    assign fin_go    = (state_reg == ST_FIN) && (!pend_valid_reg || out_free);
    assign push      = pend_valid_reg && ((emit_go && emit_keep) || fin_go);
    assign fill_next = fill_reg - used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            end_reg        <= 1'b0;
            for (int k = 0; k < MAX_KEY_CHARS; k++) win_reg[k] <= '0;
        end else begin
            if (push) begin
                out_valid_reg <= 1'b1;
                out_cp_reg    <= pend_cp_reg;
                out_last_reg  <= fin_go;
                out_eot_reg   <= fin_go && end_reg;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit_go && emit_keep) begin
                pend_valid_reg <= 1'b1;
                pend_cp_reg    <= emit_cp;
                n_reg          <= n_reg + 1'b1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && in_item.action == lmts_pkg::ACT_TEXT) begin
                        n_reg   <= '0;
                        end_reg <= in_end;
                        if (32'(fill_reg) < MAX_KEY_CHARS) begin
                            for (int k = 0; k < MAX_KEY_CHARS; k++)
                                if (fill_reg == KLW'(k)) win_reg[k] <= in_item.code_point;
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (in_end || 32'(fill_reg) + 1 >= MAX_KEY_CHARS)
                            state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    lo_reg    <= '0;
                    hi_reg    <= hi_init;
                    len_reg   <= fill_reg;
                    state_reg <= ST_SRCH;
                end
                ST_SRCH: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= mid_next;
                        i_reg     <= '0;
                        state_reg <= ST_CMP;
                    end else if (len_reg == KLW'(1)) begin
                        state_reg <= ST_PASS;
                    end else begin
                        len_reg <= len_reg - 1'b1;
                        lo_reg  <= '0;
                        hi_reg  <= hi_init;
                    end
                end
                ST_CMP: begin
                    priority if (c_eq) begin
                        used_reg  <= len_reg;
                        j_reg     <= '0;
                        state_reg <= ST_VISS;
                    end else if (c_lt) begin
                        hi_reg    <= mid_reg;
                        state_reg <= ST_SRCH;
                    end else if (c_gt) begin
                        lo_reg    <= mid_reg + 1'b1;
                        state_reg <= ST_SRCH;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_VISS: state_reg <= ST_VGET;
                ST_VGET: begin
                    if (j_reg >= val_len_q) begin
                        state_reg <= ST_SHIFT;
                    end else if (emit_go) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_VISS;
                    end
                end
                ST_PASS: begin
                    if (emit_go) begin
                        used_reg  <= KLW'(1);
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    for (int k = 0; k < MAX_KEY_CHARS; k++) begin
                        win_reg[k] <= '0;
                        for (int u = 1; u <= MAX_KEY_CHARS; u++)
                            if (used_reg == KLW'(u) && k + u < MAX_KEY_CHARS)
                                win_reg[k] <= win_reg[k + u];
                    end
                    fill_reg  <= fill_next;
                    state_reg <= (end_reg && fill_next != '0) ? ST_STEP : ST_FIN;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending result left over in idle");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= MAX_KEY_CHARS)
        else $error("window fill beyond key size");
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(n_reg) <= lmts_pkg::RESULT_CAP)
        else $error("result count beyond cap");
    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> (lo_reg <= mid_reg && mid_reg < hi_reg))
        else $error("probe outside search range");

endmodule

FILE: hdl/longest_match_text_substituter.sv
// Greedy longest-match dictionary substitution, top level.
// A write, or a text item that leaves the window not full, is taken in idle. A match step first
//   sets up the search; per tried length, up to log2(entries)+1 key probes, each comparing key
//   chars in turn until the compare decides, and a missed length retries one char shorter; a
//   hit reads and emits each value char, a pass-through the first char; then a shift, and a
//   finish per item. One item at a time; the next is taken once all its results are queued.
// Reset (aresetn, synchronous) empties window and output; the dictionary memories keep data.
module longest_match_text_substituter #(
    parameter int MAX_KEY_CHARS   = 8,
    parameter int MAX_VALUE_CHARS = 8,
    parameter int TABLE_ENTRIES   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,      // entries_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], entry_index[13:2], char_position[16:14], code_point[37:17],
    // key_length[41:38], value_length[45:42], zero[47:46]
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,        // text_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // out_code_point[20:0], zero[23:21]
    output logic        m_tlast,        // last_of_run
    output logic        m_tuser         // end_of_text
);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int KLW = $clog2(MAX_KEY_CHARS + 1);
    localparam int VLW = $clog2(MAX_VALUE_CHARS + 1);

    logic [12:0]               entries_reg;
    logic [CW-1:0]             hi_init;
    lmts_pkg::item_t           item;
    lmts_pkg::rd_req_t         key_rd, val_rd;
    logic                      wr_en;
    logic [lmts_pkg::CP_W-1:0] key_char_q, val_char_q, out_cp;
    logic [KLW-1:0]            key_len_q;
    logic [VLW-1:0]            val_len_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) entries_reg <= '0;
        else if (cfg_we) entries_reg <= cfg_wdata;
    end

    assign hi_init = (32'(entries_reg) > TABLE_ENTRIES) ? CW'(TABLE_ENTRIES) : CW'(entries_reg);
    assign item    = lmts_pkg::item_t'(s_tdata[45:0]);
    assign m_tdata = {3'b000, out_cp};

    lmts_dict #(
        .MAX_KEY_CHARS(MAX_KEY_CHARS), .MAX_VALUE_CHARS(MAX_VALUE_CHARS),
        .TABLE_ENTRIES(TABLE_ENTRIES), .KLW(KLW), .VLW(VLW)
    ) u_dict (
        .aclk(aclk), .wr_en(wr_en), .wr_item(item), .key_rd(key_rd), .val_rd(val_rd),
        .key_char_q(key_char_q), .key_len_q(key_len_q),
        .val_char_q(val_char_q), .val_len_q(val_len_q)
    );

    lmts_ctrl #(
        .MAX_KEY_CHARS(MAX_KEY_CHARS), .MAX_VALUE_CHARS(MAX_VALUE_CHARS),
        .CW(CW), .KLW(KLW), .VLW(VLW)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(item), .in_end(s_tlast), .hi_init(hi_init), .wr_en(wr_en),
        .key_rd(key_rd), .val_rd(val_rd), .key_char_q(key_char_q), .key_len_q(key_len_q),
        .val_char_q(val_char_q), .val_len_q(val_len_q),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_cp(out_cp),
        .out_last(m_tlast), .out_eot(m_tuser)
    );

endmodule
